// ===== rtl/ebs_pkg.sv =====
// Shared types and constants of the FIFO-evicting budget store.
`timescale 1ns / 1ps

package ebs_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int SIZE_BITS   = 16;

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W    = 16;
  localparam int FIELD_W = 16;
  localparam int CAP_W   = 16;
  localparam int SCOPE_W = 8;
  localparam int SUM_W   = ((SIZE_BITS > CAP_W) ? SIZE_BITS : CAP_W) + 1;

  localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(1024);
  localparam logic [SCOPE_W-1:0] SCOPE_MAX = '1;

  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [SIZE_BITS-1:0] size_t;

  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_ALLOC = 2'd2,
    OP_SHOW  = 2'd3
  } ebs_op_e;

  typedef enum logic [2:0] {
    KIND_STORED   = 3'd0,
    KIND_REJECTED = 3'd1,
    KIND_EVICTED  = 3'd2,
    KIND_VISIBLE  = 3'd3,
    KIND_SUMMARY  = 3'd4
  } ebs_kind_e;

  typedef struct packed {
    ebs_op_e             opcode;
    logic [ID_W-1:0]     entry_id;
    logic [FIELD_W-1:0]  request_size;
  } ebs_req_t;

  typedef struct packed {
    ebs_kind_e           kind;
    logic [ID_W-1:0]     out_id;
    logic [FIELD_W-1:0]  out_size;
    logic [FIELD_W-1:0]  used_total;
    logic                last;
  } ebs_res_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    size_t              size;
    logic [SCOPE_W-1:0] scope;
  } ebs_entry_t;

endpackage

// ===== rtl/ebs_entry_ram.sv =====
// Entry queue storage: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module ebs_entry_ram import ebs_pkg::*; (
  input  logic       clk_i,
  input  logic       we_i,
  input  ptr_t       waddr_i,
  input  ebs_entry_t wdata_i,
  input  ptr_t       raddr_i,
  output ebs_entry_t rdata_o
);

  ebs_entry_t mem_q [QUEUE_DEPTH];
  ebs_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fifo_evicting_budget_store.sv =====
// Top level of the FIFO-evicting budget store: sequencer, budget and scope state.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; the block works on one
// request at a time. Each result is shown on res_o for exactly one cycle with
// res_valid_o high and cannot be held off; res_o.last marks the final result of
// a request. Open and close scope give no result. Allocate evicts at most
// QUEUE_DEPTH entries before it stores or rejects; show walks the stored entries
// and ends with a summary: the walk over the entry queue reads one entry per cycle
// from its single-read-port memory. Results trail their cycle of work by one
// register stage. Capacity must be written through cfg_we_i / cfg_wdata_i only
// while the block is idle; the block itself does not enforce it. Capacity resets to 1024.

module fifo_evicting_budget_store import ebs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ebs_req_t           req_i,
  input  logic               cfg_we_i,
  input  logic [CAP_W-1:0]   cfg_wdata_i,
  output logic               res_valid_o,
  output ebs_res_t           res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVICT,    // read data holds the head entry; evict it
    ST_FINISH,   // store or reject the pending allocate
    ST_SHOW,     // read data holds the walked entry
    ST_SUMMARY
  } state_e;

  state_e             state_q, state_d;
  logic [CAP_W-1:0]   cap_q, cap_d;
  ptr_t               head_q, head_d;
  cnt_t               count_q, count_d;
  size_t              used_q, used_d;
  logic [SCOPE_W-1:0] scope_q, scope_d;
  logic [ID_W-1:0]    id_q, id_d;
  size_t              req_q, req_d;
  ptr_t               walk_ptr_q, walk_ptr_d;
  cnt_t               walk_idx_q, walk_idx_d;
  ebs_res_t           res_q, res_d;
  logic               res_valid_q, res_valid_d;

  logic       mem_we;
  ptr_t       mem_waddr;
  ebs_entry_t mem_wdata;
  ptr_t       mem_raddr;
  ebs_entry_t mem_rdata;
  size_t      req_in;
  size_t      evict_used;

  function automatic ptr_t ptr_inc(ptr_t p);
    ptr_t r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  // head + offset, wrapped; the head stays below the depth, the offset at most the depth
  function automatic ptr_t slot_add(ptr_t h, cnt_t c);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(h) + (CNT_W+1)'(c);
    if (s >= (CNT_W+1)'(QUEUE_DEPTH)) s = s - (CNT_W+1)'(QUEUE_DEPTH);
    return PTR_W'(s);
  endfunction

  function automatic logic over_budget(size_t r, size_t u, logic [CAP_W-1:0] c);
    return (SUM_W'(r) + SUM_W'(u)) > SUM_W'(c);
  endfunction

  ebs_entry_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign req_in     = SIZE_BITS'(req_i.request_size);
  assign evict_used = used_q - mem_rdata.size;

  always_comb begin
    state_d     = state_q;
    cap_d       = cap_q;
    head_d      = head_q;
    count_d     = count_q;
    used_d      = used_q;
    scope_d     = scope_q;
    id_d        = id_q;
    req_d       = req_q;
    walk_ptr_d  = walk_ptr_q;
    walk_idx_d  = walk_idx_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = slot_add(head_q, count_q);
    mem_wdata   = '{id: id_q, size: req_q, scope: scope_q};
    mem_raddr   = head_q;

    if (cfg_we_i) begin
      cap_d = cfg_wdata_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        // head entry is read every idle cycle, ready for eviction or show
        mem_raddr = head_q;
        if (start) begin
          id_d  = req_i.entry_id;
          req_d = req_in;
          unique case (req_i.opcode)
            OP_OPEN: begin
              if (scope_q != SCOPE_MAX) scope_d = scope_q + 1'b1;
            end
            OP_CLOSE: begin
              if (scope_q != '0) scope_d = scope_q - 1'b1;
            end
            OP_ALLOC: begin
              if (count_q == CNT_W'(QUEUE_DEPTH) ||
                  (count_q != '0 && over_budget(req_in, used_q, cap_q))) begin
                state_d = ST_EVICT;
              end else begin
                state_d = ST_FINISH;
              end
            end
            OP_SHOW: begin
              walk_ptr_d = head_q;
              walk_idx_d = '0;
              state_d    = (count_q == '0) ? ST_SUMMARY : ST_SHOW;
            end
            default: ;
          endcase
        end
      end

      ST_EVICT: begin
        res_valid_d = 1'b1;
        res_d = '{kind: KIND_EVICTED, out_id: mem_rdata.id,
                  out_size: FIELD_W'(mem_rdata.size),
                  used_total: FIELD_W'(evict_used), last: 1'b0};
        used_d    = evict_used;
        head_d    = ptr_inc(head_q);
        count_d   = count_q - 1'b1;
        mem_raddr = ptr_inc(head_q);
        if (!(count_q != CNT_W'(1) && over_budget(req_q, evict_used, cap_q))) begin
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        res_valid_d = 1'b1;
        if (!over_budget(req_q, used_q, cap_q) && count_q < CNT_W'(QUEUE_DEPTH)) begin
          mem_we  = 1'b1;
          count_d = count_q + 1'b1;
          used_d  = used_q + req_q;
          res_d = '{kind: KIND_STORED, out_id: id_q, out_size: FIELD_W'(req_q),
                    used_total: FIELD_W'(used_q + req_q), last: 1'b1};
        end else begin
          res_d = '{kind: KIND_REJECTED, out_id: id_q, out_size: FIELD_W'(req_q),
                    used_total: FIELD_W'(used_q), last: 1'b1};
        end
        state_d = ST_IDLE;
      end

      ST_SHOW: begin
        if (mem_rdata.size != '0 && mem_rdata.scope >= scope_q) begin
          res_valid_d = 1'b1;
          res_d = '{kind: KIND_VISIBLE, out_id: mem_rdata.id,
                    out_size: FIELD_W'(mem_rdata.size),
                    used_total: FIELD_W'(used_q), last: 1'b0};
        end
        walk_idx_d = walk_idx_q + 1'b1;
        walk_ptr_d = ptr_inc(walk_ptr_q);
        mem_raddr  = ptr_inc(walk_ptr_q);
        if (CNT_W'(walk_idx_q + 1'b1) == count_q) begin
          state_d = ST_SUMMARY;
        end
      end

      ST_SUMMARY: begin
        res_valid_d = 1'b1;
        res_d = '{kind: KIND_SUMMARY, out_id: '0, out_size: '0,
                  used_total: FIELD_W'(used_q), last: 1'b1};
        state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAP_RESET;
      head_q      <= '0;
      count_q     <= '0;
      used_q      <= '0;
      scope_q     <= '0;
      id_q        <= '0;
      req_q       <= '0;
      walk_ptr_q  <= '0;
      walk_idx_q  <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      head_q      <= head_d;
      count_q     <= count_d;
      used_q      <= used_d;
      scope_q     <= scope_d;
      id_q        <= id_d;
      req_q       <= req_d;
      walk_ptr_q  <= walk_ptr_d;
      walk_idx_q  <= walk_idx_d;
      res_q       <= res_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // final result of a request appears once the sequencer is back to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |-> !busy)
    else $error("last result while still busy");

  // intermediate results only while the request is still in work
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |-> busy)
    else $error("intermediate result while idle");

  // scope requests produce nothing
  a_scope_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.opcode == OP_OPEN || req_i.opcode == OP_CLOSE))
    |=> !res_valid_o)
    else $error("result after scope request");

  // a stored entry leaves the queue non-empty and never overfilled
  a_stored_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == KIND_STORED)
    |-> (count_q != '0 && count_q <= CNT_W'(QUEUE_DEPTH)))
    else $error("entry count inconsistent after store");

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the FIFO-evicting budget store.
`timescale 1ns / 1ps

// Requests go in through start/busy. Every request that is accepted is run through a
// shadow of the store in the same cycle. The shadow queues the reports it expects, and
// a checker pops one for each result strobe and compares it field by field.
// The receiver cannot stall, so only the sender idles. It runs at 16% idle, then 78%,
// then with no gaps.
module testbench;
  import ebs_pkg::*;

  localparam int SETTLE_CYCLES = 40;    // longest request plus the result stage
  localparam int STALL_LIMIT   = 3000;  // cycles with no request and no result accepted
  localparam int MAX_GAP       = 30;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  ebs_req_t         req_i;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_wdata_i;
  logic             res_valid_o;
  ebs_res_t         res_o;

  // Shadow copy of the store: ring of entries, budget, scope level and capacity.
  ebs_entry_t  shadow_entries [QUEUE_DEPTH];
  int unsigned shadow_head;
  int unsigned shadow_count;
  int unsigned shadow_used;
  int unsigned shadow_level;
  int unsigned shadow_capacity;

  ebs_res_t    pending_reports [$];   // reports the store still owes, oldest first
  int          error_count = 0;
  int          stall_cycles = 0;
  int unsigned idle_pct;              // percent chance per cycle that the sender holds off

  fifo_evicting_budget_store dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic flag_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  // ---------------------------------------------------------------- shadow store

  // Reports take the budget as it stands after the step they describe.
  function automatic void push_report(ebs_kind_e kind, logic [ID_W-1:0] id,
                                      logic [FIELD_W-1:0] size);
    ebs_res_t rep;
    rep.kind       = kind;
    rep.out_id     = id;
    rep.out_size   = size;
    rep.used_total = FIELD_W'(shadow_used);
    rep.last       = 1'b0;
    pending_reports.insert(pending_reports.size(), rep);
  endfunction

  function automatic void evict_oldest_entry();
    ebs_entry_t victim;
    victim = shadow_entries[shadow_head];
    shadow_used = shadow_used - victim.size;
    push_report(KIND_EVICTED, victim.id, victim.size);
    shadow_head = (shadow_head + 1) % QUEUE_DEPTH;
    shadow_count--;
  endfunction

  function automatic void predict_request(ebs_req_t r);
    int unsigned slot_idx;
    int unsigned i;
    ebs_entry_t  e;
    ebs_res_t    tail;
    case (r.opcode)
      OP_OPEN: begin
        if (shadow_level < SCOPE_MAX) shadow_level++;
      end
      OP_CLOSE: begin
        if (shadow_level > 0) shadow_level--;
      end
      OP_ALLOC: begin
        // A full ring frees its oldest slot first. Then the budget is enforced, and that
        // may run the store empty.
        if (shadow_count >= QUEUE_DEPTH) evict_oldest_entry();
        while (shadow_count > 0 && r.request_size + shadow_used > shadow_capacity)
          evict_oldest_entry();
        if (r.request_size + shadow_used <= shadow_capacity && shadow_count < QUEUE_DEPTH) begin
          slot_idx = (shadow_head + shadow_count) % QUEUE_DEPTH;
          e.id    = r.entry_id;
          e.size  = r.request_size;
          e.scope = SCOPE_W'(shadow_level);
          shadow_entries[slot_idx] = e;
          shadow_count++;
          shadow_used += r.request_size;
          push_report(KIND_STORED, r.entry_id, r.request_size);
        end else begin
          push_report(KIND_REJECTED, r.entry_id, r.request_size);
        end
      end
      OP_SHOW: begin
        // Zero-size entries never show. Neither do entries stored at a scope level below
        // the current one.
        for (i = 0; i < shadow_count; i++) begin
          e = shadow_entries[(shadow_head + i) % QUEUE_DEPTH];
          if (e.size != 0 && e.scope >= shadow_level) push_report(KIND_VISIBLE, e.id, e.size);
        end
        push_report(KIND_SUMMARY, '0, '0);
      end
      default: ;
    endcase
    if (r.opcode == OP_ALLOC || r.opcode == OP_SHOW) begin
      tail = pending_reports.pop_back();
      tail.last = 1'b1;
      pending_reports.insert(pending_reports.size(), tail);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) flag_mismatch($sformatf("%s = 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // The strobe and payload are sampled before the block's own updates for this edge.
  always @(posedge clk_i) begin : check_results
    ebs_res_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind %0d id 0x%0h", res_o.kind, res_o.out_id));
      end else begin
        want = pending_reports.pop_front();
        check_field("kind", 16'(res_o.kind), 16'(want.kind));
        check_field("out_id", res_o.out_id, want.out_id);
        check_field("out_size", res_o.out_size, want.out_size);
        check_field("used_total", res_o.used_total, want.used_total);
        check_field("last", 16'(res_o.last), 16'(want.last));
      end
    end
  end

  // The run ends here if nothing moves in either direction for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("fifo_evicting_budget_store verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- driving

  // Called at a rising edge. start stays high after acceptance when the next request
  // follows straight on, so it never gets two assignments in one step.
  task automatic send_request(ebs_op_e op, logic [15:0] id, logic [15:0] size);
    int unsigned gap;
    ebs_req_t    r;
    r.opcode       = op;
    r.entry_id     = id;
    r.request_size = size;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    predict_request(r);
  endtask

  // Hold off until every owed report is in. Then let open or close requests, which
  // give no result, finish.
  task automatic wait_for_drain();
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(int unsigned value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CAP_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_capacity = value & 32'hFFFF;
  endtask

  // Mostly sizes that let a dozen or so entries share the budget. There are some zero
  // sizes and some full-width sizes too.
  function automatic logic [15:0] random_size();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 20) return 16'($urandom);
    return 16'($urandom_range(shadow_capacity / 8 + 1));
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_directed_basics();
    send_request(OP_SHOW,  16'h0000, 16'h0000);  // empty store: summary only
    send_request(OP_CLOSE, 16'hFFFF, 16'hFFFF);  // level already zero, stays there
    send_request(OP_ALLOC, 16'hFFFF, 16'h0000);  // zero-size entry is stored
    send_request(OP_SHOW,  16'h0000, 16'h0000);  // ...but never shown
    send_request(OP_ALLOC, 16'h0001, 16'd1024);  // exactly fills the budget
    send_request(OP_ALLOC, 16'h0002, 16'h0001);  // evicts both older entries
    send_request(OP_OPEN,  16'h0000, 16'h0000);
    send_request(OP_ALLOC, 16'h0003, 16'd100);   // stored in scope 1
    send_request(OP_SHOW,  16'h0000, 16'h0000);  // only the inner entry is visible
    send_request(OP_CLOSE, 16'h0000, 16'h0000);
    send_request(OP_SHOW,  16'h0000, 16'h0000);  // both visible again, nothing freed
    send_request(OP_ALLOC, 16'h0000, 16'hFFFF);  // empties the store and is still rejected
    send_request(OP_SHOW,  16'hFFFF, 16'hFFFF);
    wait_for_drain();
    write_capacity(32'hFFFF);
    send_request(OP_ALLOC, 16'hAAAA, 16'hFFFF);  // whole budget in one entry
    send_request(OP_ALLOC, 16'h5555, 16'hFFFF);  // evicts it, takes its place
    send_request(OP_ALLOC, 16'h1234, 16'h0001);
    send_request(OP_SHOW,  16'h0000, 16'h0000);
    wait_for_drain();
    write_capacity(32'(CAP_RESET));
  endtask

  task automatic test_full_queue();
    int unsigned n;
    wait_for_drain();
    write_capacity(32'hFFFF);
    // Budget is ample, so the ring depth alone forces the evictions.
    for (n = 0; n < QUEUE_DEPTH + 2; n++)
      send_request(OP_ALLOC, 16'(n * 16'h0101), 16'($urandom_range(100)));
    send_request(OP_SHOW,  16'h0000, 16'h0000);  // a full ring walked end to end
    send_request(OP_ALLOC, 16'hBEEF, 16'hFFFF);  // evicts all entries, then fits
    send_request(OP_ALLOC, 16'hFFFF, 16'hFFFF);
    wait_for_drain();
    write_capacity(32'(CAP_RESET));
  endtask

  task automatic test_capacity_shrink();
    repeat (5) send_request(OP_ALLOC, 16'($urandom), 16'd200);
    wait_for_drain();
    write_capacity(0);                           // budget now below what is held
    send_request(OP_SHOW,  16'h0000, 16'h0000);  // used total still over capacity
    send_request(OP_ALLOC, 16'h0F0F, 16'h0000);  // evicts everything, zero size fits
    send_request(OP_ALLOC, 16'hF0F0, 16'h0001);  // evicts that, then rejected
    wait_for_drain();
    write_capacity(32'(CAP_RESET));
  endtask

  task automatic test_scope_saturation();
    repeat (256) send_request(OP_OPEN, 16'($urandom), 16'($urandom));  // last one saturates
    send_request(OP_ALLOC, 16'h00FF, 16'd5);
    send_request(OP_OPEN,  16'h0000, 16'h0000);  // still at the top level
    send_request(OP_SHOW,  16'h0000, 16'h0000);
    repeat (3) send_request(OP_CLOSE, 16'($urandom), 16'($urandom));  // top entry stays visible
    send_request(OP_SHOW,  16'h0000, 16'h0000);
  endtask

  task automatic test_random_traffic();
    int unsigned caps [6];
    int unsigned phase;
    int unsigned pick;
    caps = '{32'd65535, 32'd300, 32'd1, 32'd4096, 32'd0, 32'd0};
    caps[4] = $urandom_range(65535);
    caps[5] = $urandom_range(2000);
    for (phase = 0; phase < 6; phase++) begin
      idle_pct = (phase < 2) ? 16 : (phase < 4) ? 78 : 0;
      wait_for_drain();
      write_capacity(caps[phase]);
      repeat (14) begin
        pick = $urandom_range(99);
        // Fields that the operation ignores still carry random values.
        if (pick < 55)      send_request(OP_ALLOC, 16'($urandom), random_size());
        else if (pick < 70) send_request(OP_SHOW,  16'($urandom), 16'($urandom));
        else if (pick < 85) send_request(OP_OPEN,  16'($urandom), 16'($urandom));
        else                send_request(OP_CLOSE, 16'($urandom), 16'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------- main sequence

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    idle_pct    = 16;
    shadow_head     = 0;
    shadow_count    = 0;
    shadow_used     = 0;
    shadow_level    = 0;
    shadow_capacity = CAP_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_basics();
    test_full_queue();
    test_capacity_shrink();
    test_random_traffic();
    test_scope_saturation();

    wait_for_drain();
    if (error_count == 0) begin
      $display("fifo_evicting_budget_store verification clean");
    end else begin
      $display("fifo_evicting_budget_store verification failed");
    end
    $finish;
  end

endmodule

// ===== fifo_evicting_budget_store.f =====
rtl/ebs_pkg.sv
rtl/ebs_entry_ram.sv
rtl/fifo_evicting_budget_store.sv
bench/testbench.sv
